// ===== src/stmm_pkg.sv =====
// Package for the sliding template matcher: item types, codes and defaults.
// No dependencies.
package stmm_pkg;

  localparam int TEMPLATE_DEPTH_DEF = 1024;
  localparam int SEQUENCE_DEPTH_DEF = 16384;

  localparam logic [1:0] FN_TPL   = 2'd0;
  localparam logic [1:0] FN_SEQ   = 2'd1;
  localparam logic [1:0] FN_START = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_CLOSE    = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_SKIP_STEP  = 2'd1;
  localparam logic [1:0] REG_FRAME_RATE = 2'd2;

  localparam logic [15:0] THRESHOLD_RST  = 16'd480;
  localparam logic [7:0]  SKIP_STEP_RST  = 8'd1;
  localparam logic [7:0]  FRAME_RATE_RST = 8'd25;
  localparam logic [5:0]  TC_MAX_MS      = 6'd59;
  localparam logic [7:0]  TC_MAX_H       = 8'd255;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] position;
    logic [15:0] best_score;
    logic [7:0]  tc_hours;
    logic [5:0]  tc_minutes;
    logic [5:0]  tc_seconds;
    logic [7:0]  tc_frames;
  } out_item_t;

endpackage

// ===== src/sliding_template_mad_matcher.sv =====
// Sliding template mean-absolute-difference matcher, top level.
// Depends on stmm_pkg and stmm_ram.
//
//  port group | direction | role
//  in_*       | in        | load template/sequence sample, or start search
//  out_*      | out       | one result item per start item
//  p*         | in/out    | APB register port: threshold, skip_step, frame_rate
//
// A search visits each offset with a timecode step and a first-sample
// check; a scored offset then reads the other template samples in turn
// through the single memory read port per store, divides the sum by the
// template length in the bit-serial divider and evaluates the score. An
// empty or too long template goes straight to the result item. Synchronous
// active-low reset clears lengths, phases and registers. in_stall is high
// from search start until the result item is taken.
module sliding_template_mad_matcher #(
  parameter int TEMPLATE_DEPTH = stmm_pkg::TEMPLATE_DEPTH_DEF,
  parameter int SEQUENCE_DEPTH = stmm_pkg::SEQUENCE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stmm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stmm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import stmm_pkg::*;

  localparam int TAW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
  localparam int SAW = (SEQUENCE_DEPTH > 1) ? $clog2(SEQUENCE_DEPTH) : 1;
  localparam int LW  = $clog2(TEMPLATE_DEPTH + 1);
  localparam int NW  = $clog2(SEQUENCE_DEPTH + 1);
  localparam int SW  = 16 + LW;
  localparam int DCW = $clog2(SW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TC   = 3'd1;
  localparam logic [2:0] S_D0   = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_AD   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EVAL = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] thr_r;
  logic [7:0]  skip_r, fr_r;
  logic [LW-1:0] tlen_r, tlen_nxt;
  logic [NW-1:0] slen_r, slen_nxt;
  logic [7:0]  tph_r, tph_nxt, sph_r, sph_nxt;
  logic [NW-1:0] i_r, i_nxt, last_r, last_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [SW-1:0] sum_r, sum_nxt, quo_r, quo_nxt;
  logic [LW:0]   rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [7:0]  hh_r, hh_nxt, ff_r, ff_nxt;
  logic [5:0]  mm_r, mm_nxt, ss_r, ss_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [16:0] best_r, best_nxt;
  logic [21:0] pos_r, pos_nxt;
  logic [7:0]  rh_r, rh_nxt, rf_r, rf_nxt;
  logic [5:0]  rm_r, rm_nxt, rs_r, rs_nxt;

  logic [7:0]  skip_eff;
  logic        in_acc, cfg_wr;
  logic        t_we, s_we;
  logic [15:0] t_rd, s_rd, diff;
  logic [NW:0] saddr_full;
  logic [SAW+7:0] pos_prod;
  logic [15:0] ff_prod;
  logic [8:0]  tph_inc, sph_inc;
  logic [LW:0] div_t;

  assign skip_eff = (skip_r == 8'd0) ? 8'd1 : skip_r;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD:  prdata = {16'd0, thr_r};
      REG_SKIP_STEP:  prdata = {24'd0, skip_r};
      REG_FRAME_RATE: prdata = {24'd0, fr_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      skip_r <= SKIP_STEP_RST;
      fr_r   <= FRAME_RATE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESHOLD:  thr_r  <= pwdata[15:0];
        REG_SKIP_STEP:  skip_r <= pwdata[7:0];
        REG_FRAME_RATE: fr_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Stores
  assign tph_inc = {1'b0, tph_r} + 9'd1;
  assign sph_inc = {1'b0, sph_r} + 9'd1;
  assign t_we = in_acc && in_data.func == FN_TPL && tph_r == 8'd0
                && {{(32-LW){1'b0}}, tlen_r} < 32'(TEMPLATE_DEPTH);
  assign s_we = in_acc && in_data.func == FN_SEQ && sph_r == 8'd0
                && {{(32-NW){1'b0}}, slen_r} < 32'(SEQUENCE_DEPTH);
  assign saddr_full = {1'b0, i_r} + {{(NW+1-LW){1'b0}}, k_r};

  stmm_ram #(.WIDTH(16), .DEPTH(TEMPLATE_DEPTH), .AW(TAW)) u_tpl (
    .clk   (clk),
    .we    (t_we),
    .waddr (TAW'(tlen_r)),
    .wdata (in_data.sample),
    .raddr (TAW'(k_r)),
    .rdata (t_rd)
  );

  stmm_ram #(.WIDTH(16), .DEPTH(SEQUENCE_DEPTH), .AW(SAW)) u_seq (
    .clk   (clk),
    .we    (s_we),
    .waddr (SAW'(slen_r)),
    .wdata (in_data.sample),
    .raddr (SAW'(saddr_full)),
    .rdata (s_rd)
  );

  assign diff     = (s_rd >= t_rd) ? s_rd - t_rd : t_rd - s_rd;
  assign ff_prod  = ff_r * skip_eff;
  assign pos_prod = SAW'(i_r) * skip_eff;
  assign div_t    = {rem_r[LW-1:0], quo_r[SW-1]};

  always_comb begin
    state_nxt  = state_r;
    tlen_nxt   = tlen_r;
    slen_nxt   = slen_r;
    tph_nxt    = tph_r;
    sph_nxt    = sph_r;
    i_nxt      = i_r;
    last_nxt   = last_r;
    k_nxt      = k_r;
    sum_nxt    = sum_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dcnt_nxt   = dcnt_r;
    hh_nxt     = hh_r;
    mm_nxt     = mm_r;
    ss_nxt     = ss_r;
    ff_nxt     = ff_r;
    status_nxt = status_r;
    best_nxt   = best_r;
    pos_nxt    = pos_r;
    rh_nxt     = rh_r;
    rm_nxt     = rm_r;
    rs_nxt     = rs_r;
    rf_nxt     = rf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            FN_TPL: begin
              if (t_we) tlen_nxt = tlen_r + 1'b1;
              tph_nxt = (tph_inc >= {1'b0, skip_eff}) ? 8'd0 : tph_inc[7:0];
            end
            FN_SEQ: begin
              if (s_we) slen_nxt = slen_r + 1'b1;
              sph_nxt = (sph_inc >= {1'b0, skip_eff}) ? 8'd0 : sph_inc[7:0];
            end
            FN_START: begin
              status_nxt = ST_NONE;
              best_nxt   = 17'h10000;
              pos_nxt    = '0;
              rh_nxt = '0; rm_nxt = '0; rs_nxt = '0; rf_nxt = '0;
              hh_nxt = '0; mm_nxt = '0; ss_nxt = '0; ff_nxt = '0;
              i_nxt  = '0;
              k_nxt  = '0;
              last_nxt = slen_r - NW'(tlen_r);
              if (tlen_r == '0 || NW'(tlen_r) > slen_r) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_TC;
              end
            end
            default: ;
          endcase
        end
      end
      S_TC: begin
        if (ff_prod >= {8'd0, fr_r}) begin
          ff_nxt = '0;
          ss_nxt = ss_r + 6'd1;
        end
        if (ss_nxt > TC_MAX_MS) begin
          ss_nxt = '0;
          mm_nxt = mm_r + 6'd1;
        end
        if (mm_nxt > TC_MAX_MS) begin
          mm_nxt = '0;
          if (hh_r < TC_MAX_H) hh_nxt = hh_r + 8'd1;
        end
        state_nxt = S_D0;
      end
      S_D0: begin
        if ({16'd0, diff} < {16'd0, thr_r}) begin
          sum_nxt = SW'(diff);
          if (tlen_r == LW'(1)) begin
            state_nxt = S_DIV;
            quo_nxt   = SW'(diff);
            rem_nxt   = '0;
            dcnt_nxt  = '0;
          end else begin
            k_nxt     = LW'(1);
            state_nxt = S_RD;
          end
        end else begin
          ff_nxt = ff_r + 8'd1;
          k_nxt  = '0;
          if (i_r == last_r) begin
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_TC;
          end
        end
      end
      S_RD: state_nxt = S_AD;
      S_AD: begin
        sum_nxt = sum_r + SW'(diff);
        if (k_r == tlen_r - 1'b1) begin
          state_nxt = S_DIV;
          quo_nxt   = sum_nxt;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (div_t >= {1'b0, tlen_r}) begin
          rem_nxt = div_t - {1'b0, tlen_r};
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = div_t;
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(SW - 1)) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        logic rec;
        rec = 1'b0;
        if (sum_r == '0) begin
          status_nxt = ST_COMPLETE;
          rec = 1'b1;
        end
        if (quo_r < SW'(thr_r) && status_nxt != ST_COMPLETE) begin
          status_nxt = ST_CLOSE;
          rec = 1'b1;
        end
        if ({{(SW+1-17){1'b0}}, best_r} > {1'b0, quo_r}) begin
          best_nxt = 17'(quo_r);
          rec = 1'b1;
        end
        if (rec) begin
          pos_nxt = 22'(pos_prod);
          rh_nxt = hh_r; rm_nxt = mm_r; rs_nxt = ss_r; rf_nxt = ff_r;
        end
        k_nxt = '0;
        if (status_nxt == ST_COMPLETE) begin
          state_nxt = S_OUT;
        end else begin
          ff_nxt = ff_r + 8'd1;
          if (i_r == last_r) begin
            state_nxt = S_OUT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_TC;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
          tlen_nxt = '0;
          slen_nxt = '0;
          tph_nxt  = '0;
          sph_nxt  = '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tlen_r  <= '0;
      slen_r  <= '0;
      tph_r   <= '0;
      sph_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tlen_r  <= tlen_nxt;
      slen_r  <= slen_nxt;
      tph_r   <= tph_nxt;
      sph_r   <= sph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    last_r   <= last_nxt;
    k_r      <= k_nxt;
    sum_r    <= sum_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dcnt_r   <= dcnt_nxt;
    hh_r     <= hh_nxt;
    mm_r     <= mm_nxt;
    ss_r     <= ss_nxt;
    ff_r     <= ff_nxt;
    status_r <= status_nxt;
    best_r   <= best_nxt;
    pos_r    <= pos_nxt;
    rh_r     <= rh_nxt;
    rm_r     <= rm_nxt;
    rs_r     <= rs_nxt;
    rf_r     <= rf_nxt;
  end

  assign out_valid           = (state_r == S_OUT);
  assign out_data.status     = status_r;
  assign out_data.position   = pos_r;
  assign out_data.best_score = best_r[16] ? 16'hFFFF : best_r[15:0];
  assign out_data.tc_hours   = rh_r;
  assign out_data.tc_minutes = rm_r;
  assign out_data.tc_seconds = rs_r;
  assign out_data.tc_frames  = rf_r;

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FN_START && tlen_r == '0)
    |=> (out_valid && out_data.status == ST_EMPTY))
    else $error("empty template did not give status 3");

  a_tlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-LW){1'b0}}, tlen_r} <= 32'(TEMPLATE_DEPTH))
    else $error("template length beyond depth");

  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> (tlen_r == '0 && slen_r == '0 && tph_r == '0))
    else $error("stores not cleared after search");

  a_complete_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_COMPLETE) |-> out_data.best_score == 16'd0)
    else $error("complete match with nonzero score");

endmodule

// ===== src/stmm_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module stmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
